[rtl/core/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// rc4_pkg
// shared types and constants of the rc4 keystream engine
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
    localparam int KEY_DEPTH  = 256;
    localparam int KEY_AW     = $clog2(KEY_DEPTH);
    localparam int LEN_W      = 9;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SCHED = 2'd1,
        OP_GEN   = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_GEN   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_RJ,
        ST_KS_WI,
        ST_KS_WJ,
        ST_GEN_RJ,
        ST_GEN_SW,
        ST_GEN_WJ,
        ST_RESULT
    } state_t;

endpackage

[rtl/core/rc4_keystream_generator_top.sv]
// ----------------------------------------------------------------------------
// rc4_keystream_generator_top
// rc4 engine: key store, key schedule and keystream generation
// ----------------------------------------------------------------------------
// One item is taken at a time, and every item gives one result. A key byte
// load or an unknown opcode goes straight to the result state. A keystream
// byte needs three dependent reads and two writes on the S-box ram, which
// has one write port and one read port. A key schedule sets the identity,
// then runs a swap step for each S-box entry. After reset a clearing pass
// zeroes all 256 S-box entries before the first transfer is taken. A
// finished result waits in an output register, so the next item may be
// taken before the previous result is drained.
module rc4_keystream_generator_top
    import rc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key_byte[7:0], key_index[15:8], key_length[24:16], restart[25], zero fill
    input  logic [31:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // keystream_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_axis_tuser
);

    state_t              state_reg, state_next;
    logic [SBOX_AW-1:0]  n_reg, n_next;
    logic [KEY_AW-1:0]   kc_reg, kc_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [7:0]          i_reg, i_next;
    logic [7:0]          j_reg, j_next;
    logic [7:0]          si_reg, si_next;
    logic [7:0]          sj_reg, sj_next;
    kind_t               kind_reg, kind_next;
    logic [7:0]          byte_reg, byte_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [7:0]          out_byte_reg, out_byte_next;

    logic                accept;
    op_t                 opcode;
    logic [7:0]          key_byte;
    logic [7:0]          key_index;
    logic [LEN_W-1:0]    key_length;
    logic                restart;
    logic [LEN_W-1:0]    len_sat;
    logic [7:0]          i_base;
    logic [7:0]          t_addr;
    logic                last_n;

    logic                sbox_we, sbox_re;
    logic [SBOX_AW-1:0]  sbox_waddr, sbox_raddr;
    logic [7:0]          sbox_wdata, sbox_rdata;
    logic                key_we, key_re;
    logic [KEY_AW-1:0]   key_waddr, key_raddr;
    logic [7:0]          key_rdata;

    assign opcode     = op_t'(s_axis_tuser);
    assign key_byte   = s_axis_tdata[7:0];
    assign key_index  = s_axis_tdata[15:8];
    assign key_length = s_axis_tdata[24:16];
    assign restart    = s_axis_tdata[25];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;

    assign last_n = (n_reg == SBOX_AW'(SBOX_DEPTH - 1));
    assign i_base = restart ? 8'd0 : i_reg;
    assign t_addr = si_reg + sj_reg;

    always_comb
    begin
        if (key_length == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (key_length > LEN_W'(KEY_DEPTH))
        begin
            len_sat = LEN_W'(KEY_DEPTH);
        end
        else
        begin
            len_sat = key_length;
        end
    end

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (sbox_we),
        .waddr (sbox_waddr),
        .wdata (sbox_wdata),
        .re    (sbox_re),
        .raddr (sbox_raddr),
        .rdata (sbox_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_byte),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (last_n)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_SCHED: state_next = ST_FILL;
                        OP_GEN:   state_next = ST_GEN_RJ;
                        OP_LOAD,
                        OP_BAD:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_FILL:
            begin
                if (last_n)
                begin
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD:  state_next = ST_KS_RJ;
            ST_KS_RJ:  state_next = ST_KS_WI;
            ST_KS_WI:  state_next = ST_KS_WJ;
            ST_KS_WJ:  state_next = last_n ? ST_RESULT : ST_KS_RD;
            ST_GEN_RJ: state_next = ST_GEN_SW;
            ST_GEN_SW: state_next = ST_GEN_WJ;
            ST_GEN_WJ: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        n_next         = n_reg;
        kc_next        = kc_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;

        sbox_we    = 1'b0;
        sbox_waddr = n_reg;
        sbox_wdata = 8'd0;
        sbox_re    = 1'b0;
        sbox_raddr = n_reg;
        key_we     = 1'b0;
        key_waddr  = key_index[KEY_AW-1:0];
        key_re     = 1'b0;
        key_raddr  = kc_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                sbox_we = 1'b1;
                n_next  = n_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next = 8'd0;
                    unique case (opcode)
                        OP_LOAD:
                        begin
                            key_we    = ({1'b0, key_index} < 9'(KEY_DEPTH));
                            kind_next = KIND_KEY;
                        end
                        OP_SCHED:
                        begin
                            len_next  = len_sat;
                            n_next    = '0;
                            kind_next = KIND_SCHED;
                        end
                        OP_GEN:
                        begin
                            i_next     = i_base + 8'd1;
                            j_next     = restart ? 8'd0 : j_reg;
                            sbox_re    = 1'b1;
                            sbox_raddr = SBOX_AW'(i_base + 8'd1);
                            kind_next  = KIND_GEN;
                        end
                        OP_BAD:
                        begin
                            kind_next = KIND_BAD;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                sbox_we    = 1'b1;
                sbox_wdata = 8'(n_reg);
                n_next     = n_reg + 1'b1;
                kc_next    = '0;
                j_next     = 8'd0;
            end
            ST_KS_RD:
            begin
                sbox_re = 1'b1;
                key_re  = 1'b1;
            end
            ST_KS_RJ:
            begin
                j_next     = j_reg + sbox_rdata + key_rdata;
                si_next    = sbox_rdata;
                sbox_re    = 1'b1;
                sbox_raddr = SBOX_AW'(j_reg + sbox_rdata + key_rdata);
            end
            ST_KS_WI:
            begin
                sbox_we    = 1'b1;
                sbox_wdata = sbox_rdata;
            end
            ST_KS_WJ:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = SBOX_AW'(j_reg);
                sbox_wdata = si_reg;
                n_next     = n_reg + 1'b1;
                // key position wraps at the key length
                if (({1'b0, kc_reg} + 9'd1) == len_reg)
                begin
                    kc_next = '0;
                end
                else
                begin
                    kc_next = kc_reg + 1'b1;
                end
                if (last_n)
                begin
                    i_next = 8'd0;
                    j_next = 8'd0;
                end
            end
            ST_GEN_RJ:
            begin
                si_next    = sbox_rdata;
                j_next     = j_reg + sbox_rdata;
                sbox_re    = 1'b1;
                sbox_raddr = SBOX_AW'(j_reg + sbox_rdata);
            end
            ST_GEN_SW:
            begin
                sj_next    = sbox_rdata;
                sbox_we    = 1'b1;
                sbox_waddr = SBOX_AW'(i_reg);
                sbox_wdata = sbox_rdata;
                sbox_re    = 1'b1;
                sbox_raddr = SBOX_AW'(si_reg + sbox_rdata);
            end
            ST_GEN_WJ:
            begin
                sbox_we    = 1'b1;
                sbox_waddr = SBOX_AW'(j_reg);
                sbox_wdata = si_reg;
                // the read of s[t] predates both swap writes
                if (t_addr == j_reg)
                begin
                    byte_next = si_reg;
                end
                else if (t_addr == i_reg)
                begin
                    byte_next = sj_reg;
                end
                else
                begin
                    byte_next = sbox_rdata;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_byte_next  = byte_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            n_reg         <= '0;
            kc_reg        <= '0;
            len_reg       <= LEN_W'(1);
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            kind_reg      <= KIND_KEY;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_KEY;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            kc_reg        <= kc_next;
            len_reg       <= len_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
    end

    // a held result must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_RESULT))
        else $error("result slot overwritten while held");

    // schedule leaves both indexes at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_WJ && last_n)
        |=> (i_reg == 8'd0 && j_reg == 8'd0 && state_reg == ST_RESULT))
        else $error("indexes not cleared after schedule");

    // keystream sequence ends in a keystream result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN_WJ)
        |=> (state_reg == ST_RESULT && kind_reg == KIND_GEN))
        else $error("keystream result lost its kind");

    // no s-box write while items are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sbox_we)
        else $error("s-box written while idle");

endmodule

[rtl/core/rc4_ram.sv]
// ----------------------------------------------------------------------------
// rc4_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[bench/tb_rc4_keystream_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_keystream_generator_top
// self-checking bench for the rc4 keystream engine
// ----------------------------------------------------------------------------
// Key loads, key schedules, keystream bytes and unknown opcodes are streamed
// in with random gaps on both sides. An rc4 predictor built into the bench
// tracks the s-box, key store and indexes, and every result is checked in
// order against it. Most of the random part consists of key load, schedule
// and keystream runs; the rest is random commands.
// ----------------------------------------------------------------------------
module tb_rc4_keystream_generator_top;
    import rc4_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] data;
        bit          drain_first;
    } rc4_cmd_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] ks_byte;
    } rc4_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'h0;
    logic [1:0]  s_axis_tuser = OP_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic [7:0] sbox_m [SBOX_DEPTH] = '{default: 8'h00};
    logic [7:0] key_m [KEY_DEPTH] = '{default: 8'h00};
    logic [7:0] ptr_i = 8'h00;
    logic [7:0] ptr_j = 8'h00;

    rc4_cmd_t    cmd_q[$];
    rc4_result_t ks_expect_q[$];
    rc4_cmd_t    cur_cmd;
    bit          drain_pending = 1'b0;
    bit          offering = 1'b0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    bit          rx_hold = 1'b0;
    int          tx_gap = 0;
    int          tx_calm = 0;
    int          rx_gap = 0;
    int          rx_calm = 0;
    int          n_pushed = 0;
    int          n_accepted = 0;
    int          n_bad = 0;
    int          kinds_seen [4] = '{default: 0};

    rc4_keystream_generator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle cycles before the next transfer, with occasional stretches of none
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(16, 48);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic rc4_predict(input rc4_cmd_t c, output rc4_result_t r);
        logic [7:0] kb;
        logic [7:0] ki;
        logic [8:0] kl;
        logic [7:0] jj;
        logic [7:0] t;
        logic [7:0] tmp;
        int         len;
        int         n;
        kb = c.data[7:0];
        ki = c.data[15:8];
        kl = c.data[24:16];
        r.kind = KIND_BAD;
        r.ks_byte = 8'h00;
        case (c.op)
            OP_LOAD:
            begin
                key_m[ki] = kb;
                r.kind = KIND_KEY;
            end
            OP_SCHED:
            begin
                // zero length acts as one, lengths past the store saturate
                len = (kl == 0) ? 1 : (kl > KEY_DEPTH) ? KEY_DEPTH : int'(kl);
                for (n = 0; n < SBOX_DEPTH; n++)
                    sbox_m[n] = n[7:0];
                jj = 8'h00;
                for (n = 0; n < SBOX_DEPTH; n++)
                begin
                    jj = jj + sbox_m[n] + key_m[n % len];
                    tmp = sbox_m[n];
                    sbox_m[n] = sbox_m[jj];
                    sbox_m[jj] = tmp;
                end
                ptr_i = 8'h00;
                ptr_j = 8'h00;
                r.kind = KIND_SCHED;
            end
            OP_GEN:
            begin
                if (c.data[25])
                begin
                    ptr_i = 8'h00;
                    ptr_j = 8'h00;
                end
                ptr_i = ptr_i + 8'd1;
                ptr_j = ptr_j + sbox_m[ptr_i];
                tmp = sbox_m[ptr_i];
                sbox_m[ptr_i] = sbox_m[ptr_j];
                sbox_m[ptr_j] = tmp;
                t = sbox_m[ptr_i] + sbox_m[ptr_j];
                r.ks_byte = sbox_m[t];
                r.kind = KIND_GEN;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_cmd(input op_t op, input int kb, input int ki,
                            input int kl, input int rs);
        rc4_cmd_t c;
        c.op = op;
        c.data = {6'b0, rs[0], kl[8:0], ki[7:0], kb[7:0]};
        c.drain_first = drain_pending;
        drain_pending = 1'b0;
        cmd_q.push_back(c);
        n_pushed++;
    endtask

    // sender: one item offered at a time, random gap after each transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                offering = 1'b0;
                tx_gap = draw_wait(tx_calm);
            end
            if (!offering)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].drain_first && ks_expect_q.size() != 0))
                begin
                    cur_cmd = cmd_q.pop_front();
                    offering = 1'b1;
                    s_axis_tdata <= cur_cmd.data;
                    s_axis_tuser <= cur_cmd.op;
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    always @(posedge clk)
    begin : in_side
        rc4_result_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            rc4_predict(cur_cmd, want);
            ks_expect_q.push_back(want);
            n_accepted++;
            in_taken = 1'b1;
        end
    end

    // receiver: random stall after each transfer, plus the long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                rx_gap = draw_wait(rx_calm);
            end
            m_axis_tready <= (rx_gap == 0) && !rx_hold;
            if (rx_gap > 0)
                rx_gap--;
        end
    end

    always @(posedge clk)
    begin : out_side
        rc4_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_taken = 1'b1;
            if (ks_expect_q.size() == 0)
            begin
                if (n_bad < 10)
                    $display("unexpected result: kind %0d byte %02h",
                             m_axis_tuser, m_axis_tdata);
                n_bad++;
            end
            else
            begin
                want = ks_expect_q.pop_front();
                kinds_seen[want.kind]++;
                if (m_axis_tuser !== want.kind || m_axis_tdata !== want.ks_byte)
                begin
                    if (n_bad < 10)
                        $display("mismatch: kind exp %0d got %0d, byte exp %02h got %02h",
                                 want.kind, m_axis_tuser, want.ks_byte, m_axis_tdata);
                    n_bad++;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps going; long enough to
    // outlast two back-to-back key schedules
    initial
    begin : rx_hold_off
        wait (n_accepted >= 320);
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stim
        int seq;
        int klen;
        int ngen;
        int pick;
        int k;

        // generate before any schedule works on the all-zero s-box
        push_cmd(OP_GEN, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 511), 1);
        push_cmd(OP_GEN, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 511), 0);
        push_cmd(OP_BAD, 'hff, 'hff, 'h1ff, 1);
        push_cmd(OP_LOAD, 'hff, 0, 0, 0);
        push_cmd(OP_LOAD, 'h00, 255, 'h1ff, 1);
        push_cmd(OP_LOAD, 'h00, 1, 0, 0);
        // zero length behaves as length one
        push_cmd(OP_SCHED, 'h00, 'h00, 0, 0);
        push_cmd(OP_GEN, 'h00, 'h00, 0, 1);
        push_cmd(OP_GEN, 'h00, 'h00, 0, 0);
        push_cmd(OP_GEN, 'h00, 'h00, 0, 0);
        push_cmd(OP_SCHED, 'hff, 'hff, 2, 1);
        push_cmd(OP_GEN, 'hff, 'hff, 'h1ff, 1);
        push_cmd(OP_BAD, 'h00, 'h00, 0, 0);
        push_cmd(OP_GEN, 'hff, 'hff, 'h1ff, 0);
        push_cmd(OP_LOAD, 'h80, 2, 0, 0);
        push_cmd(OP_SCHED, 'h00, 'h00, 3, 0);
        // schedule clears the indexes, so no restart is needed here
        push_cmd(OP_GEN, 'h00, 'h00, 0, 0);
        push_cmd(OP_GEN, 'h00, 'h00, 0, 1);
        push_cmd(OP_GEN, 'h00, 'h00, 0, 0);
        drain_pending = 1'b1;

        seq = 0;
        while (n_pushed < 1250)
        begin
            if (seq % 8 == 7)
                drain_pending = 1'b1;
            pick = (seq == 0) ? 99 : $urandom_range(0, 99);
            if (seq == 0)
                klen = KEY_DEPTH;
            else if (pick < 8)
                klen = $urandom_range(17, 64);
            else
                klen = $urandom_range(1, 16);
            if (pick >= 20 && pick < 25)
            begin
                // whole key store is written by now: oversize lengths saturate
                push_cmd(OP_SCHED, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(256, 511), $urandom_range(0, 1));
            end
            else if (pick >= 25 || seq == 0)
            begin
                for (k = 0; k < klen; k++)
                    push_cmd(OP_LOAD, $urandom_range(0, 255), k,
                             $urandom_range(0, 511), $urandom_range(0, 1));
                push_cmd(OP_SCHED, $urandom_range(0, 255), $urandom_range(0, 255),
                         (klen == 1 && $urandom_range(0, 1) == 0) ? 0 : klen,
                         $urandom_range(0, 1));
            end
            if (pick >= 20 || seq == 0)
            begin
                ngen = $urandom_range(4, 30);
                for (k = 0; k < ngen; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        push_cmd(OP_BAD, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 511), $urandom_range(0, 1));
                    push_cmd(OP_GEN, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 511),
                             int'((k == 0) || ($urandom_range(0, 11) == 0)));
                end
            end
            else
            begin
                // random commands with random fields
                repeat ($urandom_range(1, 6))
                    push_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 511),
                             $urandom_range(0, 1));
            end
            seq++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (n_accepted != n_pushed || ks_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d transfers in %0d sequences: %0d key loads, %0d schedules,",
                 n_accepted, seq, kinds_seen[KIND_KEY], kinds_seen[KIND_SCHED]);
        $display("%0d keystream bytes, %0d unknown opcodes, %0d mismatches",
                 kinds_seen[KIND_GEN], kinds_seen[KIND_BAD], n_bad);
        if (n_bad == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
